>>> rtl/core/ps2md_pkg.sv
// Package for the PS/2 mouse packet decoder: types, header bits and scaling constants.
package ps2md_pkg;

  typedef enum logic [1:0] {
    POS_HEADER = 2'd0,
    POS_X      = 2'd1,
    POS_Y      = 2'd2
  } pos_t;

  typedef enum logic {
    CFG_SENSITIVITY = 1'b0,
    CFG_ENABLE      = 1'b1
  } cfg_idx_t;

  localparam int HDR_SYNC_BIT  = 3;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;
  localparam int HDR_XOVF_BIT  = 6;
  localparam int HDR_YOVF_BIT  = 7;

  localparam logic [8:0] SENS_MIN   = 9'd10;
  localparam logic [8:0] SENS_MAX   = 9'd500;
  localparam logic [8:0] SENS_RESET = 9'd100;

  localparam logic [6:0]  LIMIT     = 7'd100;
  // |v * sens| at or above this gives a quotient beyond LIMIT
  localparam logic [16:0] CLAMP_MAG = 17'd10100;
  // floor(a / 100) = (a * RECIP_100) >> RECIP_SHIFT for a < CLAMP_MAG
  localparam logic [15:0] RECIP_100   = 16'd41944;
  localparam int          RECIP_SHIFT = 22;

  typedef struct packed {
    logic [16:0] mag;
    logic        neg;
  } axis_prod_t;

endpackage

>>> rtl/core/ps2_mouse_packet_decoder.sv
// PS/2 mouse packet decoder top level: packet framing, scaling pipeline and config registers.
//
// Bytes from the controller are framed into 3-byte mouse packets; keyboard bytes and all
// bytes while disabled are dropped, and a packet starts only on a byte with bit 3 set.
// One byte is accepted per cycle while in_stall is low. Each completed packet passes a
// three-register pipeline (captured bytes in s1, magnitude times sensitivity in s2,
// reciprocal divide by 100 with clamp in the output register). in_stall rises only when
// the pipeline is full and out_stall holds the output register. Configuration writes
// take effect on the next cycle.
module ps2_mouse_packet_decoder
  import ps2md_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [8:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic              in_from_aux,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] out_delta_x,
  output logic signed [7:0] out_delta_y,
  output logic [2:0]        out_button_bits
);

  logic [8:0] sens_r;
  logic       enable_r;

  pos_t       pos_r, pos_nxt;
  logic [7:0] header_r, header_nxt;
  logic [7:0] x_byte_r, x_byte_nxt;
  logic       load_s1;

  logic       s1_v_r;
  logic [7:0] s1_hdr_r, s1_x_r, s1_y_r;

  logic       s2_v_r;
  axis_prod_t s2_x_r, s2_y_r;
  logic [2:0] s2_btn_r;

  logic              out_valid_r;
  logic signed [7:0] dx_r, dy_r;
  logic [2:0]        btn_r;

  logic ready1, ready2, ready3, accept, hit;

  assign ready3   = !out_valid_r || !out_stall;
  assign ready2   = !s2_v_r || ready3;
  assign ready1   = !s1_v_r || ready2;
  assign in_stall = !ready1;
  assign accept   = in_valid && ready1;
  assign hit      = accept && enable_r && in_from_aux;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r   <= SENS_RESET;
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SENSITIVITY: begin
          if (cfg_data < SENS_MIN) begin
            sens_r <= SENS_MIN;
          end else if (cfg_data > SENS_MAX) begin
            sens_r <= SENS_MAX;
          end else begin
            sens_r <= cfg_data;
          end
        end
        CFG_ENABLE: enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // packet framing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_HEADER;
      header_r <= '0;
      x_byte_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      header_r <= header_nxt;
      x_byte_r <= x_byte_nxt;
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    header_nxt = header_r;
    x_byte_nxt = x_byte_r;
    load_s1    = 1'b0;
    case (pos_r)
      POS_X: begin
        if (hit) begin
          x_byte_nxt = in_rx_byte;
          pos_nxt    = POS_Y;
        end
      end
      POS_Y: begin
        if (hit) begin
          pos_nxt = POS_HEADER;
          load_s1 = 1'b1;
        end
      end
      default: begin
        if (hit) begin
          if (in_rx_byte[HDR_SYNC_BIT]) begin
            header_nxt = in_rx_byte;
            pos_nxt    = POS_X;
          end else begin
            pos_nxt = POS_HEADER;
          end
        end
      end
    endcase
  end

  // stage 1: captured packet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (load_s1) begin
      s1_v_r <= 1'b1;
    end else if (ready2) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_s1) begin
      s1_hdr_r <= header_r;
      s1_x_r   <= x_byte_r;
      s1_y_r   <= in_rx_byte;
    end
  end

  // stage 2: magnitude times sensitivity
  function automatic axis_prod_t axis_mult(input logic [7:0] low8, input logic sgn,
                                           input logic ovf, input logic [8:0] sens);
    axis_prod_t  res;
    logic [8:0]  v;
    logic [8:0]  mag;
    logic [17:0] prod;
    v    = ovf ? 9'd0 : {sgn, low8};
    mag  = (sgn && !ovf) ? (9'd0 - v) : v;
    prod = mag * sens;
    res.mag = prod[16:0];
    res.neg = sgn && !ovf;
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (ready2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_v_r) begin
      s2_x_r   <= axis_mult(s1_x_r, s1_hdr_r[HDR_XSIGN_BIT], s1_hdr_r[HDR_XOVF_BIT], sens_r);
      s2_y_r   <= axis_mult(s1_y_r, s1_hdr_r[HDR_YSIGN_BIT], s1_hdr_r[HDR_YOVF_BIT], sens_r);
      s2_btn_r <= s1_hdr_r[2:0];
    end
  end

  // stage 3: divide by 100 toward zero, clamp, apply sign (inverted for Y)
  function automatic logic [7:0] axis_scale(input axis_prod_t p, input logic flip);
    logic [29:0] q;
    logic [6:0]  mag;
    logic [7:0]  m8;
    q   = p.mag[13:0] * RECIP_100;
    mag = (p.mag >= CLAMP_MAG) ? LIMIT : q[RECIP_SHIFT+6:RECIP_SHIFT];
    m8  = {1'b0, mag};
    return (p.neg ^ flip) ? (8'd0 - m8) : m8;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready3) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && s2_v_r) begin
      dx_r  <= axis_scale(s2_x_r, 1'b0);
      dy_r  <= axis_scale(s2_y_r, 1'b1);
      btn_r <= s2_btn_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_delta_x     = dx_r;
  assign out_delta_y     = dy_r;
  assign out_button_bits = btn_r;

endmodule
